@@ rtl/conv3x3_replicate_border_assert.svh @@
// Assertion macros shared by the conv3x3_replicate_border RTL.
`ifndef CONV3X3_REPLICATE_BORDER_ASSERT_SVH
`define CONV3X3_REPLICATE_BORDER_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define CNV_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define CNV_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/cnv_pkg.sv @@
// Package: types, constants and helpers of the 3x3 replicate-border convolution.
package cnv_pkg;

  localparam int unsigned MAX_WIDTH_DEF   = 1024;
  localparam int unsigned SCALE_FRAC_BITS = 14;
  localparam int unsigned HEIGHT_LIMIT    = 4096;

  localparam int unsigned PIX_W        = 8;
  localparam int unsigned TAP_W        = 5;
  localparam int unsigned IMG_WIDTH_W  = 11;
  localparam int unsigned IMG_HEIGHT_W = 13;
  localparam int unsigned COEF_ROW_W   = 15;
  localparam int unsigned SCALE_W      = 16;
  localparam int unsigned CFG_DATA_W   = 16;
  localparam int unsigned CFG_IDX_W    = 3;
  // input row runs up to height + 1 during the tail
  localparam int unsigned ROW_W        = 13;
  localparam int unsigned OUT_ROW_W    = 12;
  // 9 products of a 5-bit tap and an 8-bit pixel
  localparam int unsigned TERM_W       = TAP_W + PIX_W + 1;
  localparam int unsigned SUM_W        = TERM_W + 3;

  localparam logic [IMG_WIDTH_W-1:0]  IMG_WIDTH_RST  = 11'd640;
  localparam logic [IMG_HEIGHT_W-1:0] IMG_HEIGHT_RST = 13'd480;
  localparam logic [COEF_ROW_W-1:0]   COEF_TOP_RST   = 15'd32767;
  localparam logic [COEF_ROW_W-1:0]   COEF_MID_RST   = 15'd32063;
  localparam logic [COEF_ROW_W-1:0]   COEF_BOT_RST   = 15'd32767;
  localparam logic [SCALE_W-1:0]      SCALE_RST      = 16'd16384;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMG_WIDTH  = 3'd0,
    REG_IMG_HEIGHT = 3'd1,
    REG_COEF_TOP   = 3'd2,
    REG_COEF_MID   = 3'd3,
    REG_COEF_BOT   = 3'd4,
    REG_SCALE      = 3'd5
  } cfg_reg_e;

  typedef enum logic {
    FUNC_PIXEL = 1'b0,
    FUNC_DRAIN = 1'b1
  } func_e;

  typedef struct packed {
    func_e            func;
    logic [PIX_W-1:0] pixel_in;
  } in_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_out;
    logic             frame_end;
  } out_item_t;

  typedef struct packed {
    logic [IMG_WIDTH_W-1:0]  img_width;
    logic [IMG_HEIGHT_W-1:0] img_height;
    logic [COEF_ROW_W-1:0]   coef_top_row;
    logic [COEF_ROW_W-1:0]   coef_mid_row;
    logic [COEF_ROW_W-1:0]   coef_bot_row;
    logic [SCALE_W-1:0]      scale_q14;
  } cfg_t;

  // 3x3 pixel block, outer index first
  typedef logic [2:0][2:0][PIX_W-1:0] pix_win_t;

  // Border-resolved neighborhood handed to the MAC, pix[row][col]
  typedef struct packed {
    logic     valid;
    logic     frame_end;
    pix_win_t pix;
  } job_t;

  function automatic logic signed [TAP_W-1:0] tap_of(input logic [COEF_ROW_W-1:0] row,
                                                    input int unsigned k);
    return $signed(row[k*TAP_W +: TAP_W]);
  endfunction

endpackage

@@ rtl/cnv_ram.sv @@
// Generic simple dual-port RAM with registered read.
module cnv_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/cnv_ctrl.sv @@
// Line-memory sequencer: raster counters, read-modify-write of the rows, 3x3 window.
`include "conv3x3_replicate_border_assert.svh"

module cnv_ctrl import cnv_pkg::*; #(
  parameter int unsigned MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  cfg_t     cfg_i,
  input  logic     restart_i,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_item_t in_item_i,
  input  logic     job_ready_i,
  output job_t     job_o
);

  localparam int unsigned COL_W = $clog2(MAX_WIDTH);
  localparam int unsigned WID_W = $clog2(MAX_WIDTH + 1);
  localparam int unsigned CMP_W = (WID_W > IMG_WIDTH_W) ? WID_W : IMG_WIDTH_W;
  localparam int unsigned MEM_W = 2 * PIX_W;

  typedef enum logic {
    ST_IDLE,
    ST_RMW
  } state_e;

  state_e                  state_q;
  logic [COL_W-1:0]        in_col_q;
  logic [ROW_W-1:0]        in_row_q;
  logic [COL_W-1:0]        out_col_q;
  logic [OUT_ROW_W-1:0]    out_row_q;
  logic                    in_tail_q;
  logic [PIX_W-1:0]        pix_q;
  pix_win_t                win_q;   // win_q[col][row], col 2 is the newest

  logic [CMP_W-1:0]        w_eff;
  logic [CMP_W-1:0]        img_w_ext;
  logic [IMG_HEIGHT_W-1:0] h_eff;
  logic                    in_acc;
  logic                    skip;
  logic [MEM_W-1:0]        ram_rdata;
  logic [PIX_W-1:0]        above;
  logic [PIX_W-1:0]        current;
  logic [PIX_W-1:0]        bottom;
  logic                    ram_we;
  pix_win_t                win_d;
  logic                    col_wrap;
  logic [COL_W-1:0]        in_col_d;
  logic [ROW_W-1:0]        in_row_d;
  logic                    tail_d;
  logic                    emit;
  logic                    out_col_last;
  logic                    out_row_last;
  logic                    frame_last;
  logic [2:0][1:0]         csel;
  logic [2:0][1:0]         rsel;

  // Clamp the geometry into the supported range
  assign img_w_ext = CMP_W'(cfg_i.img_width);
  assign w_eff = (img_w_ext == '0) ? CMP_W'(1) :
                 (img_w_ext > CMP_W'(MAX_WIDTH)) ? CMP_W'(MAX_WIDTH) : img_w_ext;
  assign h_eff = (cfg_i.img_height == '0) ? IMG_HEIGHT_W'(1) :
                 (cfg_i.img_height > IMG_HEIGHT_W'(HEIGHT_LIMIT)) ?
                 IMG_HEIGHT_W'(HEIGHT_LIMIT) : cfg_i.img_height;

  // Take a new item only when the MAC front stage is free at issue time
  assign in_stall_o = !((state_q == ST_IDLE) && job_ready_i);
  assign in_acc     = in_valid_i && !in_stall_o;
  // drain outside the tail: drop it
  assign skip       = !in_tail_q && (in_item_i.func == FUNC_DRAIN);

  assign above   = ram_rdata[MEM_W-1:PIX_W];
  assign current = ram_rdata[PIX_W-1:0];
  assign bottom  = in_tail_q ? current : pix_q;
  assign ram_we  = (state_q == ST_RMW) && !in_tail_q;

  cnv_ram #(
    .WIDTH (MEM_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (in_col_q),
    .wdata_i ({current, pix_q}),
    .re_i    (in_acc),
    .raddr_i (in_col_q),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    win_d       = win_q;
    win_d[0]    = win_q[1];
    win_d[1]    = win_q[2];
    win_d[2][0] = above;
    win_d[2][1] = current;
    win_d[2][2] = bottom;
  end

  assign col_wrap = (CMP_W'(in_col_q) + CMP_W'(1)) >= w_eff;
  assign in_col_d = col_wrap ? '0 : in_col_q + COL_W'(1);
  assign in_row_d = col_wrap ? in_row_q + ROW_W'(1) : in_row_q;
  assign tail_d   = in_tail_q || (in_row_d >= ROW_W'(h_eff));
  assign emit     = (in_row_q >= ROW_W'(2)) || ((in_row_q == ROW_W'(1)) && (in_col_q != '0));

  assign out_col_last = (CMP_W'(out_col_q) + CMP_W'(1)) >= w_eff;
  assign out_row_last = (ROW_W'(out_row_q) + ROW_W'(1)) >= ROW_W'(h_eff);
  assign frame_last   = out_col_last && out_row_last;

  // Replicate the edge column or row where the neighbor lies outside the frame
  assign csel[0] = (out_col_q == '0) ? 2'd1 : 2'd0;
  assign csel[1] = 2'd1;
  assign csel[2] = out_col_last ? 2'd1 : 2'd2;
  assign rsel[0] = (out_row_q == '0) ? 2'd1 : 2'd0;
  assign rsel[1] = 2'd1;
  assign rsel[2] = out_row_last ? 2'd1 : 2'd2;

  always_comb begin
    job_o.valid     = (state_q == ST_RMW) && emit;
    job_o.frame_end = frame_last;
    for (int unsigned r = 0; r < 3; r++) begin
      for (int unsigned c = 0; c < 3; c++) begin
        job_o.pix[r][c] = win_d[csel[c]][rsel[r]];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
      in_tail_q <= 1'b0;
      pix_q     <= '0;
      win_q     <= '0;
    end else if (restart_i) begin
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
      in_tail_q <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc && !skip) begin
            pix_q   <= in_item_i.pixel_in;
            state_q <= ST_RMW;
          end
        end
        ST_RMW: begin
          win_q   <= win_d;
          state_q <= ST_IDLE;
          if (emit && frame_last) begin
            in_col_q  <= '0;
            in_row_q  <= '0;
            out_col_q <= '0;
            out_row_q <= '0;
            in_tail_q <= 1'b0;
          end else begin
            in_col_q  <= in_col_d;
            in_row_q  <= in_row_d;
            in_tail_q <= tail_d;
            if (emit) begin
              if (out_col_last) begin
                out_col_q <= '0;
                out_row_q <= out_row_q + OUT_ROW_W'(1);
              end else begin
                out_col_q <= out_col_q + COL_W'(1);
              end
            end
          end
        end
      endcase
    end
  end

  `CNV_ASSERT_IMP(a_col_in_frame, 1'b1, CMP_W'(in_col_q) < w_eff, "input column left the frame")
  `CNV_ASSERT_IMP(a_tail_rows, in_tail_q, in_row_q >= ROW_W'(h_eff), "tail set inside the frame")
  `CNV_ASSERT_IMP(a_wr_after_rd, ram_we, $past(in_acc), "line write without a preceding read")

endmodule

@@ rtl/cnv_mac.sv @@
// Weighted 3x3 sum, gain, floor and clamp, with the output register.
`include "conv3x3_replicate_border_assert.svh"

module cnv_mac import cnv_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  job_t      job_i,
  output logic      job_ready_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  localparam int unsigned MAG_W  = SUM_W - 1;
  localparam int unsigned PROD_W = MAG_W + SCALE_W;

  logic                    s0_v_q;
  logic                    s0_end_q;
  pix_win_t                s0_pix_q;
  logic                    s1_v_q;
  logic                    s1_end_q;
  logic signed [SUM_W-1:0] s1_sum_q;
  logic                    out_v_q;
  out_item_t               out_item_q;

  logic                           out_move;
  logic                           s1_free;
  logic                           s1_move;
  logic                           s0_move;
  logic [2:0][COEF_ROW_W-1:0]     rows;
  logic signed [TERM_W-1:0]       terms [3][3];
  logic signed [SUM_W-1:0]        sum_d;
  logic [PROD_W-1:0]              prod;
  logic                           s1_nonpos;
  logic [PIX_W-1:0]               pix_res;

  // Advance each stage when the next one is empty or moving on
  assign out_move    = !out_v_q || !out_stall_i;
  assign s1_move     = s1_v_q && out_move;
  assign s1_free     = !s1_v_q || out_move;
  assign s0_move     = s0_v_q && s1_free;
  assign job_ready_o = !s0_v_q || s1_free;

  assign rows[0] = cfg_i.coef_top_row;
  assign rows[1] = cfg_i.coef_mid_row;
  assign rows[2] = cfg_i.coef_bot_row;

  always_comb begin
    sum_d = '0;
    for (int unsigned r = 0; r < 3; r++) begin
      for (int unsigned c = 0; c < 3; c++) begin
        terms[r][c] = tap_of(rows[r], c) * $signed({1'b0, s0_pix_q[r][c]});
        sum_d = sum_d + {{(SUM_W-TERM_W){terms[r][c][TERM_W-1]}}, terms[r][c]};
      end
    end
  end

  // Only a positive sum reaches the gain, so its magnitude bits suffice
  assign s1_nonpos = s1_sum_q[SUM_W-1] || (s1_sum_q == '0);
  assign prod      = PROD_W'(s1_sum_q[MAG_W-1:0]) * PROD_W'(cfg_i.scale_q14);
  assign pix_res   = s1_nonpos ? '0 :
                     (|prod[PROD_W-1:SCALE_FRAC_BITS+PIX_W]) ? '1 :
                     prod[SCALE_FRAC_BITS+PIX_W-1:SCALE_FRAC_BITS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q  <= 1'b0;
      s1_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (job_i.valid) begin
        s0_v_q <= 1'b1;
      end else if (s0_move) begin
        s0_v_q <= 1'b0;
      end
      if (s0_move) begin
        s1_v_q <= 1'b1;
      end else if (s1_move) begin
        s1_v_q <= 1'b0;
      end
      if (s1_move) begin
        out_v_q <= 1'b1;
      end else if (out_move) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_i.valid) begin
      s0_pix_q <= job_i.pix;
      s0_end_q <= job_i.frame_end;
    end
    if (s0_move) begin
      s1_sum_q <= sum_d;
      s1_end_q <= s0_end_q;
    end
    if (s1_move) begin
      out_item_q.pixel_out <= pix_res;
      out_item_q.frame_end <= s1_end_q;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_item_o  = out_item_q;

  `CNV_ASSERT_IMP(a_no_overrun, job_i.valid, job_ready_o, "job issued into a busy front stage")
  `CNV_ASSERT_NXT(a_floor_zero, s1_move && s1_nonpos, out_item_q.pixel_out == '0, "nonpositive sum gave nonzero pixel")
  `CNV_ASSERT_IMP(a_out_source, $rose(out_v_q), $past(s1_v_q), "result appeared without a sum")

endmodule

@@ rtl/conv3x3_replicate_border.sv @@
// Top level: configuration registers, line-memory sequencer and MAC output path.
//
// Streaming 3x3 convolution of 8-bit grey pixels in raster order, with edge
// pixels repeated at the frame border. Each input transfer carries a pixel
// item or a drain item; the result for pixel (x,y) leaves with the transfer
// that follows it by one row plus one pixel, and after the last pixel of a
// frame another width + 1 items (drains, or pixels that are then treated as
// drains) flush the remaining results. The last result of a frame has
// frame_end set, and the block is then ready for the next frame. The block
// takes no new input item while the last one is in its read-modify-write
// cycle: the two previous rows share one line memory that is read in the
// cycle the item is accepted and written back in the cycle after, and the
// next item waits for that write. Drain items outside the tail are dropped.
// A result reaches out_valid_o through the sum, gain and output stages,
// which queue up to three results, so a stalled output only holds off input
// once they are full. Writing img_width or img_height restarts the frame;
// write configuration only while no transfer is in flight. The line memory
// needs no clearing pass after reset: entries that were never written are
// always replaced by replicated border pixels before they reach a result.
`include "conv3x3_replicate_border_assert.svh"

module conv3x3_replicate_border import cnv_pkg::*; #(
  parameter int unsigned MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration write port
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // input channel
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_item_t              in_item_i,
  // result channel
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_item_t             out_item_o
);

  cfg_t cfg_q;
  logic restart;
  logic job_ready;
  job_t job;

  // A geometry write restarts the frame in the same cycle it lands
  assign restart = cfg_we_i && ((cfg_idx_i == REG_IMG_WIDTH) || (cfg_idx_i == REG_IMG_HEIGHT));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.img_width    <= IMG_WIDTH_RST;
      cfg_q.img_height   <= IMG_HEIGHT_RST;
      cfg_q.coef_top_row <= COEF_TOP_RST;
      cfg_q.coef_mid_row <= COEF_MID_RST;
      cfg_q.coef_bot_row <= COEF_BOT_RST;
      cfg_q.scale_q14    <= SCALE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_IMG_WIDTH:  cfg_q.img_width    <= cfg_data_i[IMG_WIDTH_W-1:0];
        REG_IMG_HEIGHT: cfg_q.img_height   <= cfg_data_i[IMG_HEIGHT_W-1:0];
        REG_COEF_TOP:   cfg_q.coef_top_row <= cfg_data_i[COEF_ROW_W-1:0];
        REG_COEF_MID:   cfg_q.coef_mid_row <= cfg_data_i[COEF_ROW_W-1:0];
        REG_COEF_BOT:   cfg_q.coef_bot_row <= cfg_data_i[COEF_ROW_W-1:0];
        REG_SCALE:      cfg_q.scale_q14    <= cfg_data_i[SCALE_W-1:0];
        default: begin
          // unused index: drop the write
        end
      endcase
    end
  end

  cnv_ctrl #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .restart_i   (restart),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .job_ready_i (job_ready),
    .job_o       (job)
  );

  cnv_mac u_mac (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .job_i       (job),
    .job_ready_o (job_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  `CNV_ASSERT_NXT(a_pixel_rmw, in_valid_i && !in_stall_o && !restart && (in_item_i.func == FUNC_PIXEL),
                  in_stall_o, "pixel transfer took no write-back cycle")

endmodule

@@ tb/conv3x3_checker.sv @@
`timescale 1ns / 100ps
// Checker: predicts every filtered pixel from the observed transfers and compares results.
module conv3x3_checker import cnv_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  in_item_t              in_item_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  out_item_t             out_item_i,
  output int unsigned           fail_count_o,
  output int unsigned           pending_o
);

  logic [IMG_WIDTH_W-1:0]  width_q;
  logic [IMG_HEIGHT_W-1:0] height_q;
  logic [COEF_ROW_W-1:0]   taps_q [3];
  logic [SCALE_W-1:0]      gain_q;

  logic [PIX_W-1:0] row_above   [MAX_WIDTH_DEF];
  logic [PIX_W-1:0] row_current [MAX_WIDTH_DEF];
  logic [PIX_W-1:0] win [3][3];  // [column: left, centre, right][row: top, mid, bottom]

  int unsigned in_col, in_row, out_col, out_row;
  bit          in_tail;
  int unsigned fails;
  out_item_t   expected_pixels [$];

  function automatic void rewind_frame();
    in_col  = 0;
    in_row  = 0;
    out_col = 0;
    out_row = 0;
    in_tail = 1'b0;
  endfunction

  // Advance the line buffers and window by one item; queue the pixel it releases.
  function automatic void convolve_item(in_item_t item);
    int unsigned      wd, ht, c;
    int unsigned      cs [3];
    int unsigned      rs [3];
    int               sum;
    longint           scaled;
    logic [PIX_W-1:0] above, mid, below;
    bit               emit, last;
    out_item_t        res;

    wd = (width_q == 0) ? 1 : ((width_q > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : width_q);
    ht = (height_q == 0) ? 1 : ((height_q > HEIGHT_LIMIT) ? HEIGHT_LIMIT : height_q);

    // a drain outside the tail is dropped without effect
    if (!in_tail && item.func == FUNC_DRAIN) return;

    c     = (in_col < MAX_WIDTH_DEF) ? in_col : 0;
    above = row_above[c];
    mid   = row_current[c];
    if (!in_tail) begin
      below          = item.pixel_in;
      row_above[c]   = mid;
      row_current[c] = below;
    end else begin
      below = mid;
    end
    for (int r = 0; r < 3; r++) begin
      win[0][r] = win[1][r];
      win[1][r] = win[2][r];
    end
    win[2][0] = above;
    win[2][1] = mid;
    win[2][2] = below;

    emit = (in_row >= 2) || (in_row == 1 && in_col >= 1);
    if (in_col + 1 >= wd) begin
      in_col = 0;
      in_row++;
    end else begin
      in_col++;
    end
    if (!in_tail && in_row >= ht) in_tail = 1'b1;
    if (!emit) return;

    // replicate the border by steering edge taps onto the centre row or column
    cs[0] = (out_col == 0) ? 1 : 0;
    cs[1] = 1;
    cs[2] = (out_col + 1 >= wd) ? 1 : 2;
    rs[0] = (out_row == 0) ? 1 : 0;
    rs[1] = 1;
    rs[2] = (out_row + 1 >= ht) ? 1 : 2;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        sum += int'($signed(taps_q[i][TAP_W*j +: TAP_W])) * int'(win[cs[j]][rs[i]]);
      end
    end

    if (sum <= 0) begin
      res.pixel_out = '0;
    end else begin
      scaled = (longint'(sum) * longint'(gain_q)) >>> SCALE_FRAC_BITS;
      res.pixel_out = (scaled > 255) ? 8'd255 : scaled[PIX_W-1:0];
    end
    last          = (out_col + 1 >= wd) && (out_row + 1 >= ht);
    res.frame_end = last;
    expected_pixels.push_back(res);

    if (last) begin
      rewind_frame();
    end else if (out_col + 1 >= wd) begin
      out_col = 0;
      out_row++;
    end else begin
      out_col++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      width_q   = IMG_WIDTH_RST;
      height_q  = IMG_HEIGHT_RST;
      taps_q[0] = COEF_TOP_RST;
      taps_q[1] = COEF_MID_RST;
      taps_q[2] = COEF_BOT_RST;
      gain_q    = SCALE_RST;
      for (int k = 0; k < MAX_WIDTH_DEF; k++) begin
        row_above[k]   = '0;
        row_current[k] = '0;
      end
      for (int k = 0; k < 9; k++) win[k / 3][k % 3] = '0;
      rewind_frame();
      expected_pixels.delete();
      fails = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_IMG_WIDTH: begin
            width_q = cfg_data_i[IMG_WIDTH_W-1:0];
            rewind_frame();
          end
          REG_IMG_HEIGHT: begin
            height_q = cfg_data_i[IMG_HEIGHT_W-1:0];
            rewind_frame();
          end
          REG_COEF_TOP: taps_q[0] = cfg_data_i[COEF_ROW_W-1:0];
          REG_COEF_MID: taps_q[1] = cfg_data_i[COEF_ROW_W-1:0];
          REG_COEF_BOT: taps_q[2] = cfg_data_i[COEF_ROW_W-1:0];
          REG_SCALE:    gain_q    = cfg_data_i[SCALE_W-1:0];
          default: ;
        endcase
      end

      if (out_valid_i && !out_stall_i) begin
        if (expected_pixels.size() == 0) begin
          $error("unexpected result: pixel_out %0d, frame_end %0d",
                 out_item_i.pixel_out, out_item_i.frame_end);
          fails++;
        end else begin
          want = expected_pixels.pop_front();
          if (out_item_i.pixel_out !== want.pixel_out) begin
            $error("pixel_out: expected %0d, got %0d", want.pixel_out, out_item_i.pixel_out);
            fails++;
          end
          if (out_item_i.frame_end !== want.frame_end) begin
            $error("frame_end: expected %0d, got %0d", want.frame_end, out_item_i.frame_end);
            fails++;
          end
        end
      end

      if (in_valid_i && !in_stall_i) convolve_item(in_item_i);
    end
    fail_count_o <= fails;
    pending_o    <= expected_pixels.size();
  end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// Testbench top: clock, reset, stimulus and verdict for the 3x3 replicate-border filter.
module testbench;
  import cnv_pkg::*;

  localparam int unsigned TOTAL_ITEMS    = 1600;
  // a drained block may still be dropping a drain or finishing a write-back
  localparam int unsigned SETTLE_CYCLES  = 12;
  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam int unsigned IDLE_PCT       = 25;
  localparam int unsigned RAND_MAX_W     = 12;
  localparam int unsigned RAND_MAX_H     = 6;
  localparam int unsigned WIDE_ITEMS     = 1100;
  // index past the last register: the block must ignore it
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx   = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  in_item_t              in_item   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_item;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned idle_pct     = IDLE_PCT;
  int unsigned quiet_cycles = 0;
  // effective geometry as the block sees it, used to shape frames
  int unsigned geo_w = 640;
  int unsigned geo_h = 480;

  conv3x3_replicate_border dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item)
  );

  conv3x3_checker checker_i (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_item_i    (in_item),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_item_i   (out_item),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Stall the result side at random; idle_pct drops to zero for the quiet stretch.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < idle_pct);
  end

  // Abort when nothing moves on any port for too long.
  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // One register write; lower the enable in a later step so writes never collide.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we   <= 1'b0;
    @(posedge clk);
  endtask

  // Write both geometry registers (restarts the frame) and track the clamped size.
  task automatic set_geometry(input logic [CFG_DATA_W-1:0] wdata,
                              input logic [CFG_DATA_W-1:0] hdata);
    write_reg(REG_IMG_WIDTH, wdata);
    write_reg(REG_IMG_HEIGHT, hdata);
    geo_w = wdata[IMG_WIDTH_W-1:0];
    geo_h = hdata[IMG_HEIGHT_W-1:0];
    if (geo_w == 0) geo_w = 1;
    if (geo_w > MAX_WIDTH_DEF) geo_w = MAX_WIDTH_DEF;
    if (geo_h == 0) geo_h = 1;
    if (geo_h > HEIGHT_LIMIT) geo_h = HEIGHT_LIMIT;
  endtask

  // Offer one item after a random gap; return at the edge of its transfer with valid
  // still high so back-to-back items stream without a bubble.
  task automatic send_item(input func_e f, input logic [PIX_W-1:0] px);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= '{func: f, pixel_in: px};
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Hold off the sender until every expected result is back, then let the block settle.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Stream frames of the current geometry. With breaks set, sprinkle stray drains,
  // cut frames short (the next geometry write restarts mid-frame) and cut tails
  // short (the next frame's first pixels then act as drains).
  task automatic send_frames(input int unsigned nframes, input bit breaks,
                             output int unsigned sent);
    int unsigned npix, ntail;
    sent = 0;
    repeat (nframes) begin
      npix  = geo_w * geo_h;
      ntail = geo_w + 1;
      if (breaks && $urandom_range(9) == 0) begin
        npix = $urandom_range(npix);
        for (int unsigned k = 0; k < npix; k++) send_item(FUNC_PIXEL, 8'($urandom));
        sent += npix;
        return;
      end
      if (breaks && $urandom_range(9) == 0) ntail = $urandom_range(geo_w);
      for (int unsigned k = 0; k < npix; k++) begin
        if (breaks && $urandom_range(19) == 0) send_item(FUNC_DRAIN, 8'($urandom));
        send_item(FUNC_PIXEL, 8'($urandom));
      end
      // flush the tail with a mix of drains and pixels that count as drains
      for (int unsigned k = 0; k < ntail; k++) begin
        send_item($urandom_range(1) ? FUNC_DRAIN : FUNC_PIXEL, 8'($urandom));
      end
      sent += npix + ntail;
    end
  endtask

  // Fresh gain and (usually) taps and geometry for a random phase.
  task automatic random_setup();
    logic [CFG_DATA_W-1:0] gain;
    if (geo_w > RAND_MAX_W || geo_h > RAND_MAX_H || $urandom_range(3) != 0) begin
      // junk in the upper data bits must be masked off by the block
      set_geometry({5'($urandom),
                    ($urandom_range(9) == 0) ? 11'd0 : 11'($urandom_range(1, RAND_MAX_W))},
                   {3'($urandom),
                    ($urandom_range(9) == 0) ? 13'd0 : 13'($urandom_range(1, RAND_MAX_H))});
    end
    if ($urandom_range(3) != 0) write_reg(REG_COEF_TOP, 16'($urandom));
    if ($urandom_range(3) != 0) write_reg(REG_COEF_MID, 16'($urandom));
    if ($urandom_range(3) != 0) write_reg(REG_COEF_BOT, 16'($urandom));
    case ($urandom_range(7))
      0:       gain = '0;
      1:       gain = '1;
      2:       gain = 16'h4000;
      default: gain = 16'($urandom_range(0, 16'h1000));
    endcase
    write_reg(REG_SCALE, gain);
    if ($urandom_range(7) == 0) write_reg(REG_SPARE, 16'($urandom));
  endtask

  initial begin
    int unsigned phase, total_items, sent;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: a 3x2 frame with extreme taps and full gain.
    set_geometry(16'd3, 16'd2);
    write_reg(REG_COEF_TOP, 16'h41F0);  // -16, 15, -16
    write_reg(REG_COEF_MID, 16'h3E0F);  // 15, -16, 15
    write_reg(REG_COEF_BOT, 16'hC210);  // -16 on all three, junk in bit 15
    write_reg(REG_SCALE, 16'hFFFF);
    write_reg(REG_SPARE, 16'h0001);
    send_item(FUNC_DRAIN, 8'hFF);       // nothing to flush yet: dropped
    send_item(FUNC_PIXEL, 8'h00);
    send_item(FUNC_PIXEL, 8'hFF);
    send_item(FUNC_PIXEL, 8'h01);
    send_item(FUNC_PIXEL, 8'h80);
    send_item(FUNC_PIXEL, 8'hFF);
    send_item(FUNC_PIXEL, 8'h00);
    send_item(FUNC_DRAIN, 8'h00);
    send_item(FUNC_PIXEL, 8'hAA);       // pixel in the tail acts as a drain
    send_item(FUNC_DRAIN, 8'h55);
    send_item(FUNC_DRAIN, 8'h00);
    settle();

    // Zero geometry clamps to a single pixel; zero gain forces a zero result.
    set_geometry(16'hF800, 16'hE000);
    write_reg(REG_SCALE, 16'h0000);
    send_item(FUNC_PIXEL, 8'h7F);
    send_item(FUNC_DRAIN, 8'h00);
    send_item(FUNC_DRAIN, 8'h00);
    settle();
    write_reg(REG_COEF_MID, 16'h01E0);  // centre 15 only
    write_reg(REG_SCALE, 16'h4000);
    send_item(FUNC_PIXEL, 8'h80);
    send_item(FUNC_DRAIN, 8'h00);
    send_item(FUNC_DRAIN, 8'h00);

    // Random phases, each started from an idle block. One phase runs the clamped
    // width with no idling; every phase counts toward the total.
    phase       = 0;
    total_items = 0;
    while (total_items < TOTAL_ITEMS || phase <= 10) begin
      settle();
      case (phase)
        10: begin
          // clamped width, no idling on either side, cut off mid-frame
          idle_pct = 0;
          set_geometry(16'hFFFF, 16'd2);
          repeat (WIDE_ITEMS) send_item(FUNC_PIXEL, 8'($urandom));
          total_items += WIDE_ITEMS;
          idle_pct = IDLE_PCT;
        end
        default: begin
          random_setup();
          send_frames($urandom_range(1, 3), 1'b1, sent);
          total_items += sent;
        end
      endcase
      phase++;
    end

    settle();
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ conv3x3_replicate_border.f @@
+incdir+rtl
rtl/cnv_pkg.sv
rtl/cnv_ram.sv
rtl/cnv_ctrl.sv
rtl/cnv_mac.sv
rtl/conv3x3_replicate_border.sv
tb/conv3x3_checker.sv
tb/testbench.sv
